// ===== rtl/ils_pkg.sv =====
// ----------------------------------------------------------------------------
// ils_pkg: shared types and constants of the indexed list store
// Item layouts, command and status codes, and the broadcast to the cells.
// ----------------------------------------------------------------------------
package ils_pkg;

    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;

    // Fixed field widths of the items
    localparam int CMD_W    = 3;
    localparam int IDX_W    = 7;
    localparam int VALUE_W  = 32;
    localparam int READ_W   = 32;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    // Derived widths
    localparam int POS_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [IDX_W-1:0]   index;
        logic [VALUE_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [READ_W-1:0]   read_value;
        logic [COUNT_W-1:0]  count;
        logic [STATUS_W-1:0] status;
    } t_out_item;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_READ   = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op              op;
        logic [POS_W-1:0]      pos;
        logic [DATA_WIDTH-1:0] value;
    } t_cell_cmd;

endpackage

// ===== rtl/ils_cell.sv =====
// ----------------------------------------------------------------------------
// ils_cell: one list entry
// Holds one data word; loads from its lower or upper neighbour on a shift,
// takes the broadcast value at the insert position, and answers a read.
// ----------------------------------------------------------------------------
module ils_cell (
    input  logic                          i_clk,
    input  logic [ils_pkg::POS_W-1:0]     i_pos,
    input  ils_pkg::t_cell_cmd            i_cmd,
    input  logic [ils_pkg::DATA_WIDTH-1:0] i_lower,
    input  logic [ils_pkg::DATA_WIDTH-1:0] i_upper,
    output logic [ils_pkg::DATA_WIDTH-1:0] o_data,
    output logic [ils_pkg::DATA_WIDTH-1:0] o_rd_data
);

    logic [ils_pkg::DATA_WIDTH-1:0] r_data;
    logic [ils_pkg::DATA_WIDTH-1:0] n_data;

    always_comb begin
        n_data = r_data;
        case (i_cmd.op)
            ils_pkg::OP_INSERT: begin
                if (i_pos > i_cmd.pos) begin
                    n_data = i_lower;
                end else if (i_pos == i_cmd.pos) begin
                    n_data = i_cmd.value;
                end
            end
            ils_pkg::OP_REMOVE: begin
                if (i_pos >= i_cmd.pos) begin
                    n_data = i_upper;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data    = r_data;
    assign o_rd_data = (i_cmd.op == ils_pkg::OP_READ && i_pos == i_cmd.pos) ? r_data : '0;

endmodule

// ===== rtl/ils_chain.sv =====
// ----------------------------------------------------------------------------
// ils_chain: row of list cells
// Links each cell to its neighbours and merges the cells' read answers.
// ----------------------------------------------------------------------------
module ils_chain (
    input  logic                           i_clk,
    input  ils_pkg::t_cell_cmd             i_cmd,
    output logic [ils_pkg::DATA_WIDTH-1:0] o_rd_data
);

    logic [ils_pkg::DATA_WIDTH-1:0] w_data [ils_pkg::CAPACITY];
    logic [ils_pkg::DATA_WIDTH-1:0] w_rd   [ils_pkg::CAPACITY];

    for (genvar g = 0; g < ils_pkg::CAPACITY; g++) begin : g_cell
        logic [ils_pkg::DATA_WIDTH-1:0] w_lower;
        logic [ils_pkg::DATA_WIDTH-1:0] w_upper;

        if (g == 0) begin : g_first
            assign w_lower = '0;
        end else begin : g_mid_lo
            assign w_lower = w_data[g-1];
        end

        if (g == ils_pkg::CAPACITY - 1) begin : g_last
            assign w_upper = '0;
        end else begin : g_mid_hi
            assign w_upper = w_data[g+1];
        end

        ils_cell u_cell (
            .i_clk     (i_clk),
            .i_pos     (ils_pkg::POS_W'(g)),
            .i_cmd     (i_cmd),
            .i_lower   (w_lower),
            .i_upper   (w_upper),
            .o_data    (w_data[g]),
            .o_rd_data (w_rd[g])
        );
    end

    // At most one cell answers a read, so merge by OR
    always_comb begin
        o_rd_data = '0;
        for (int k = 0; k < ils_pkg::CAPACITY; k++) begin
            o_rd_data = o_rd_data | w_rd[k];
        end
    end

endmodule

// ===== rtl/indexed_list_store.sv =====
// ----------------------------------------------------------------------------
// indexed_list_store: ordered list with insert and remove by index
// Checks each command against the entry count, broadcasts it to the row of
// cells, and registers the result item.
// ----------------------------------------------------------------------------
// The result item is registered: it is valid in the cycle after its input item is taken.
// Throughput: one item per cycle unless the output stalls; every cell shifts to
// its neighbour in the same cycle, so insert and remove cost no more than append or read.
// Reset clears the entry count and the output valid; entry contents are not
// cleared and need no clearing pass.
module indexed_list_store (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ils_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ils_pkg::t_out_item o_out_item
);

    logic [ils_pkg::CNT_W-1:0]      r_count;
    logic [ils_pkg::CNT_W-1:0]      n_count;
    logic                           r_out_valid;
    ils_pkg::t_out_item             r_out_item;
    logic [ils_pkg::STATUS_W-1:0]   w_status;
    ils_pkg::t_cell_cmd             w_cmd;
    ils_pkg::t_cell_cmd             w_chain_cmd;
    logic [ils_pkg::DATA_WIDTH-1:0] w_rd_data;
    logic [ils_pkg::CMP_W-1:0]      w_idx;
    logic [ils_pkg::CMP_W-1:0]      w_cnt;
    logic                           w_full;
    logic                           w_accept;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign w_accept   = i_in_valid & ~o_in_stall;

    assign w_idx  = ils_pkg::CMP_W'(i_in_item.index);
    assign w_cnt  = ils_pkg::CMP_W'(r_count);
    assign w_full = (w_cnt >= ils_pkg::CMP_W'(ils_pkg::CAPACITY));

    always_comb begin
        n_count     = r_count;
        w_status    = ils_pkg::ST_OK;
        w_cmd.op    = ils_pkg::OP_HOLD;
        w_cmd.pos   = ils_pkg::POS_W'(i_in_item.index);
        w_cmd.value = ils_pkg::DATA_WIDTH'(i_in_item.value);
        case (i_in_item.command)
            ils_pkg::CMD_APPEND: begin
                if (w_full) begin
                    w_status = ils_pkg::ST_FULL;
                end else begin
                    w_cmd.op  = ils_pkg::OP_INSERT;
                    w_cmd.pos = ils_pkg::POS_W'(r_count);
                    n_count   = ils_pkg::CNT_W'(r_count + 1'b1);
                end
            end
            ils_pkg::CMD_INSERT: begin
                // index is checked before fullness
                if (w_idx > w_cnt) begin
                    w_status = ils_pkg::ST_RANGE;
                end else if (w_full) begin
                    w_status = ils_pkg::ST_FULL;
                end else begin
                    w_cmd.op = ils_pkg::OP_INSERT;
                    n_count  = ils_pkg::CNT_W'(r_count + 1'b1);
                end
            end
            ils_pkg::CMD_REMOVE: begin
                if (w_idx >= w_cnt) begin
                    w_status = ils_pkg::ST_RANGE;
                end else begin
                    w_cmd.op = ils_pkg::OP_REMOVE;
                    n_count  = ils_pkg::CNT_W'(r_count - 1'b1);
                end
            end
            ils_pkg::CMD_READ: begin
                if (w_idx >= w_cnt) begin
                    w_status = ils_pkg::ST_RANGE;
                end else begin
                    w_cmd.op = ils_pkg::OP_READ;
                end
            end
            ils_pkg::CMD_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // Hold the cells unless an item is taken
    always_comb begin
        w_chain_cmd = w_cmd;
        if (!w_accept) begin
            w_chain_cmd.op = ils_pkg::OP_HOLD;
        end
    end

    ils_chain u_chain (
        .i_clk     (i_clk),
        .i_cmd     (w_chain_cmd),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_item.read_value <= ils_pkg::READ_W'(w_rd_data);
            r_out_item.count      <= ils_pkg::COUNT_W'(n_count);
            r_out_item.status     <= w_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== test/indexed_list_store_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// indexed_list_store_tb: self-checking bench for the indexed list store
// Sends directed and phased random commands through the valid/stall input,
// mirrors the list in a local predictor and checks every result item in
// order, with random idling on both sides.
// ----------------------------------------------------------------------------
module indexed_list_store_tb;

    localparam int RANDOM_ITEMS = 900;
    localparam int CYCLE_LIMIT  = 60000;
    localparam int IDLE_PCT     = 7;
    localparam int QUIET_FROM   = 400;
    localparam int QUIET_TO     = 750;
    localparam int DRAIN_CYCLES = 8;

    typedef enum int {MIX_GROW, MIX_SHRINK, MIX_BOTH} t_mix;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_taken  = 1'b0;
    logic               out_stall = 1'b0;
    ils_pkg::t_in_item  in_item   = '0;
    logic               in_stall;
    logic               out_valid;
    ils_pkg::t_out_item out_item;

    // stimulus side
    ils_pkg::t_in_item  pending_cmds[$];
    int                 plan_len = 0;

    // predictor side
    logic [ils_pkg::DATA_WIDTH-1:0] list_mem [ils_pkg::CAPACITY];
    int                 list_len = 0;
    ils_pkg::t_out_item expected_replies[$];

    int        cycles      = 0;
    int        errors      = 0;
    int        items_taken = 0;
    int        replies_ok  = 0;
    int        full_hits   = 0;
    int        range_hits  = 0;
    int        peak_len    = 0;
    logic      noisy;

    indexed_list_store u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    always #5 clk = ~clk;

    assign noisy = !(cycles >= QUIET_FROM && cycles < QUIET_TO);

    // Apply one command to the mirrored list and return the result it gives.
    function automatic ils_pkg::t_out_item list_apply(ils_pkg::t_in_item it);
        ils_pkg::t_out_item r;
        int                 pos;
        r   = '0;
        pos = int'(it.index);
        case (it.command)
            ils_pkg::CMD_APPEND: begin
                if (list_len >= ils_pkg::CAPACITY) begin
                    r.status = ils_pkg::ST_FULL;
                end else begin
                    list_mem[list_len] = it.value[ils_pkg::DATA_WIDTH-1:0];
                    list_len++;
                end
            end
            ils_pkg::CMD_INSERT: begin
                // index is checked before fullness
                if (pos > list_len) begin
                    r.status = ils_pkg::ST_RANGE;
                end else if (list_len >= ils_pkg::CAPACITY) begin
                    r.status = ils_pkg::ST_FULL;
                end else begin
                    for (int i = list_len; i > pos; i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[pos] = it.value[ils_pkg::DATA_WIDTH-1:0];
                    list_len++;
                end
            end
            ils_pkg::CMD_REMOVE: begin
                if (pos >= list_len) begin
                    r.status = ils_pkg::ST_RANGE;
                end else begin
                    for (int i = pos; i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i+1];
                    list_len--;
                end
            end
            ils_pkg::CMD_READ: begin
                if (pos >= list_len)
                    r.status = ils_pkg::ST_RANGE;
                else
                    r.read_value = ils_pkg::READ_W'(list_mem[pos]);
            end
            ils_pkg::CMD_CLEAR: begin
                list_len = 0;
            end
            default: ;
        endcase
        r.count = ils_pkg::COUNT_W'(list_len);
        return r;
    endfunction

    // Queue a command and track the length it leaves, to steer the indexes.
    task automatic plan_item(logic [ils_pkg::CMD_W-1:0] c, logic [ils_pkg::IDX_W-1:0] x,
                             logic [ils_pkg::VALUE_W-1:0] v);
        ils_pkg::t_in_item it;
        it.command = c;
        it.index   = x;
        it.value   = v;
        pending_cmds.push_back(it);
        case (c)
            ils_pkg::CMD_APPEND:
                if (plan_len < ils_pkg::CAPACITY) plan_len++;
            ils_pkg::CMD_INSERT:
                if (int'(x) <= plan_len && plan_len < ils_pkg::CAPACITY) plan_len++;
            ils_pkg::CMD_REMOVE:
                if (int'(x) < plan_len) plan_len--;
            ils_pkg::CMD_CLEAR:
                plan_len = 0;
            default: ;
        endcase
    endtask

    // Driver: present a new item once the previous one has gone.
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_taken) begin
            if (pending_cmds.size() != 0 &&
                !(noisy && $urandom_range(0, 99) < IDLE_PCT)) begin
                in_item  <= pending_cmds.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
        out_stall <= noisy && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // Monitor: predict on each accepted input, check each accepted result.
    always @(posedge clk) begin
        ils_pkg::t_out_item want;
        ils_pkg::t_out_item got;
        cycles <= cycles + 1;
        if (!rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall) begin
                want = list_apply(in_item);
                expected_replies.push_back(want);
                items_taken++;
                if (want.status == ils_pkg::ST_FULL)  full_hits++;
                if (want.status == ils_pkg::ST_RANGE) range_hits++;
                if (list_len > peak_len)              peak_len = list_len;
            end
            if (out_valid && !out_stall) begin
                got = out_item;
                if (expected_replies.size() == 0) begin
                    $display("%0t: unexpected result item %h", $realtime, got);
                    errors++;
                end else begin
                    want = expected_replies.pop_front();
                    if (got.read_value !== want.read_value) begin
                        $display("%0t: read_value expected %h actual %h",
                                 $realtime, want.read_value, got.read_value);
                        errors++;
                    end
                    if (got.count !== want.count) begin
                        $display("%0t: count expected %0d actual %0d",
                                 $realtime, want.count, got.count);
                        errors++;
                    end
                    if (got.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $realtime, want.status, got.status);
                        errors++;
                    end
                    replies_ok++;
                end
            end
        end
    end

    initial begin
        t_mix                         mix;
        int                           phase_left;
        int                           r;
        int                           top;
        logic [ils_pkg::CMD_W-1:0]    c;
        logic [ils_pkg::CMD_W-1:0]    spare;
        logic [ils_pkg::IDX_W-1:0]    x;
        logic [ils_pkg::VALUE_W-1:0]  v;

        // empty list: every indexed access is out of range
        plan_item(ils_pkg::CMD_READ,   '0, '0);
        plan_item(ils_pkg::CMD_REMOVE, '0, '0);
        plan_item(ils_pkg::CMD_INSERT, ils_pkg::IDX_W'(1), '1);
        plan_item(ils_pkg::CMD_CLEAR,  '0, '0);
        // build a short list through head, tail and middle inserts
        plan_item(ils_pkg::CMD_INSERT, '0, '1);
        plan_item(ils_pkg::CMD_APPEND, '1, '0);
        plan_item(ils_pkg::CMD_INSERT, ils_pkg::IDX_W'(2), 32'hA5A5_A5A5);
        plan_item(ils_pkg::CMD_INSERT, ils_pkg::IDX_W'(1), 32'h1234_5678);
        plan_item(ils_pkg::CMD_INSERT, '0, 32'h5A5A_5A5A);
        for (int i = 0; i < 5; i++)
            plan_item(ils_pkg::CMD_READ, ils_pkg::IDX_W'(i), '1);
        plan_item(ils_pkg::CMD_READ,   '1, '0);
        plan_item(ils_pkg::CMD_INSERT, ils_pkg::IDX_W'(6), '1);
        // remove head, tail, then middle
        plan_item(ils_pkg::CMD_REMOVE, '0, '1);
        plan_item(ils_pkg::CMD_REMOVE, ils_pkg::IDX_W'(3), '0);
        plan_item(ils_pkg::CMD_REMOVE, ils_pkg::IDX_W'(1), '0);
        for (int k = int'(ils_pkg::CMD_CLEAR) + 1; k < (1 << ils_pkg::CMD_W); k++)
            plan_item(ils_pkg::CMD_W'(k), '1, '1);
        plan_item(ils_pkg::CMD_CLEAR, '1, '1);
        plan_item(ils_pkg::CMD_READ,  '0, '0);

        // random phases; open with a grow phase so the list fills early
        mix        = MIX_GROW;
        phase_left = 110;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (phase_left == 0) begin
                mix        = t_mix'($urandom_range(0, 2));
                phase_left = $urandom_range(30, 90);
            end
            phase_left--;
            spare = ils_pkg::CMD_W'($urandom_range(int'(ils_pkg::CMD_CLEAR) + 1,
                                                   (1 << ils_pkg::CMD_W) - 1));
            r = $urandom_range(0, 99);
            case (mix)
                MIX_GROW:
                    c = (r < 45) ? ils_pkg::CMD_APPEND :
                        (r < 80) ? ils_pkg::CMD_INSERT :
                        (r < 90) ? ils_pkg::CMD_READ   :
                        (r < 97) ? ils_pkg::CMD_REMOVE : spare;
                MIX_SHRINK:
                    c = (r < 60) ? ils_pkg::CMD_REMOVE :
                        (r < 80) ? ils_pkg::CMD_READ   :
                        (r < 88) ? ils_pkg::CMD_APPEND :
                        (r < 95) ? ils_pkg::CMD_INSERT :
                        (r < 97) ? ils_pkg::CMD_CLEAR  : spare;
                default:
                    c = (r < 20) ? ils_pkg::CMD_APPEND :
                        (r < 40) ? ils_pkg::CMD_INSERT :
                        (r < 60) ? ils_pkg::CMD_REMOVE :
                        (r < 88) ? ils_pkg::CMD_READ   :
                        (r < 93) ? ils_pkg::CMD_CLEAR  : spare;
            endcase
            top = (c == ils_pkg::CMD_INSERT) ? plan_len : plan_len - 1;
            if (top < 0) top = 0;
            r = $urandom_range(0, 99);
            if (r < 70)
                x = ils_pkg::IDX_W'($urandom_range(0, top));
            else if (r < 85)
                x = ils_pkg::IDX_W'((r % 2 == 0) ? plan_len : top);
            else
                x = ils_pkg::IDX_W'($urandom_range(0, (1 << ils_pkg::IDX_W) - 1));
            r = $urandom_range(0, 99);
            v = (r < 5) ? '0 : (r < 10) ? '1 : ils_pkg::VALUE_W'($urandom());
            plan_item(c, x, v);
        end

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        while ((pending_cmds.size() != 0 || in_valid || expected_replies.size() != 0)
               && cycles < CYCLE_LIMIT)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (cycles >= CYCLE_LIMIT)
            $display("%0t: timed out after %0d cycles", $realtime, cycles);
        if (expected_replies.size() != 0) begin
            $display("%0t: %0d result items never arrived", $realtime,
                     expected_replies.size());
            errors += expected_replies.size();
        end
        $display("%0d items in, %0d results checked, %0d errors", items_taken,
                 replies_ok, errors);
        $display("list full %0d times, index out of range %0d times, peak length %0d",
                 full_hits, range_hits, peak_len);
        if (errors == 0 && cycles < CYCLE_LIMIT)
            $display("indexed_list_store_tb: done, clean");
        else
            $display("indexed_list_store_tb: done, errors");
        $finish;
    end

endmodule
